// ===== src/quadratic_root_in_interval_unit_assert.svh =====
// assertion macros used by the bound checker in src/qrii_checker.sv
`ifndef QUADRATIC_ROOT_IN_INTERVAL_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_IN_INTERVAL_UNIT_ASSERT_SVH

// generic clocked property, disabled in reset
`define QRII_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrii check failed");

// a stalled transfer keeps its valid and payload
`define QRII_ASSERT_HOLD(lbl, vld, rdy, dat) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(dat))) \
    else $error("qrii stalled transfer changed");

`endif

// ===== src/qrii_pkg.sv =====
`default_nettype none
package qrii_pkg;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] root;
  } out_item_t;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_A_ZERO   = 2'd1;
  localparam logic [1:0] ST_NEG_DISC = 2'd2;
  localparam logic [1:0] ST_NO_ROOT  = 2'd3;

endpackage
`default_nettype wire

// ===== src/quadratic_root_in_interval_unit.sv =====
// Quadratic root picker: one equation a*x^2 + b*x + c in signed fixed point per transfer,
// returning the smaller root strictly inside (bound_low, bound_high), else the larger,
// else a status code. A new transfer can be taken every cycle while the pipe is not halted;
// results leave in order, after the bit-per-stage square root and the two bit-per-stage root
// dividers. The whole pipeline advances together: it halts only while a finished result
// waits on out_ready, and then in_ready drops in the same cycle.
`default_nettype none
module quadratic_root_in_interval_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  qrii_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output qrii_pkg::out_item_t  out_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = 2 * DW;        // product width
  localparam int DSW = 2 * DW + 2;    // discriminant width
  localparam int SQW = DW + 1;        // square root bits
  localparam int NMW = DW + 1;        // numerator magnitude bits
  localparam int QW  = NMW + FB;      // dividend and quotient bits
  localparam int DVW = DW + 1;        // divisor |2a| bits

  localparam logic signed [QW:0] MAXV = ({{QW{1'b0}}, 1'b1} << (DW - 1)) - 1'b1;
  localparam logic signed [QW:0] MINV = -MAXV - 1'b1;

  // sideband carried alongside the stages from stage 2 to the sign stage
  typedef struct packed {
    logic                 a_zero;
    logic                 neg;
    logic                 a_neg;
    logic [DVW-1:0]       den;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
  } side_t;

  // whole pipe moves unless the output register is full and stalled
  logic adv;
  logic out_valid_r;
  qrii_pkg::out_item_t out_data_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- stage 1: capture, keep the significant bits
  logic                 v1_r;
  logic signed [DW-1:0] a1_r, b1_r, c1_r, lo1_r, hi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= in_data.coef_a[DW-1:0];
      b1_r  <= in_data.coef_b[DW-1:0];
      c1_r  <= in_data.coef_c[DW-1:0];
      lo1_r <= in_data.bound_low[DW-1:0];
      hi1_r <= in_data.bound_high[DW-1:0];
    end
  end

  // ---------------- stage 2: b*b and a*c, one multiplier each
  logic                 v2_r;
  logic signed [PW-1:0] bb2_r, ac2_r;
  side_t                side2_r;
  side_t                side2_nxt;
  logic [DVW-1:0]       abs_a;

  always_comb begin
    abs_a = a1_r[DW-1] ? -DVW'(a1_r) : DVW'(a1_r);
    side2_nxt.a_zero = (a1_r == '0);
    side2_nxt.neg    = 1'b0;
    side2_nxt.a_neg  = a1_r[DW-1];
    side2_nxt.den    = abs_a << 1;   // |2a|
    side2_nxt.b      = b1_r;
    side2_nxt.lo     = lo1_r;
    side2_nxt.hi     = hi1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb2_r   <= b1_r * b1_r;
      ac2_r   <= a1_r * c1_r;
      side2_r <= side2_nxt;
    end
  end

  // ---------------- stage 3: discriminant, which is also sqrt stage 0
  logic                  sq_v_r    [SQW+1];
  side_t                 sq_side_r [SQW+1];
  logic [DSW-1:0]        sq_d_r    [SQW+1];
  logic [SQW:0]          sq_rem_r  [SQW+1];
  logic [SQW-1:0]        sq_root_r [SQW+1];
  logic signed [DSW-1:0] diff;
  side_t                 side3_nxt;

  always_comb begin
    diff = DSW'(bb2_r) - (DSW'(ac2_r) <<< 2);
    side3_nxt     = side2_r;
    side3_nxt.neg = diff[DSW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= side3_nxt;
      sq_d_r[0]    <= diff[DSW-1] ? '0 : diff;   // negative case gives sqrt of zero
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // ---------------- square root, one root bit per stage
  for (genvar k = 1; k <= SQW; k++) begin : g_sqrt
    logic [SQW+2:0] cur_nxt, tst_nxt;
    logic           take_nxt;

    always_comb begin
      cur_nxt  = {sq_rem_r[k-1], sq_d_r[k-1][DSW-1:DSW-2]};
      tst_nxt  = {1'b0, sq_root_r[k-1], 2'b01};
      take_nxt = (cur_nxt >= tst_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k] <= sq_side_r[k-1];
        sq_d_r[k]    <= sq_d_r[k-1] << 2;
        sq_rem_r[k]  <= take_nxt ? (SQW+1)'(cur_nxt - tst_nxt) : (SQW+1)'(cur_nxt);
        sq_root_r[k] <= {sq_root_r[k-1][SQW-2:0], take_nxt};
      end
    end
  end

  // ---------------- numerators -b +- s, which is also divider stage 0
  logic           dv_v_r    [QW+1];
  side_t          dv_side_r [QW+1];
  logic [QW-1:0]  dv_n_r    [QW+1][2];
  logic [DVW-1:0] dv_rem_r  [QW+1][2];
  logic [QW-1:0]  dv_q_r    [QW+1][2];
  logic           dv_sgn_r  [QW+1][2];

  logic signed [DW+1:0] nb, sx, num0, num1;
  logic [NMW-1:0]       mag0, mag1;

  always_comb begin
    nb   = -(DW+2)'(sq_side_r[SQW].b);
    sx   = $signed({1'b0, sq_root_r[SQW]});
    num0 = nb + sx;
    num1 = nb - sx;
    mag0 = num0[DW+1] ? NMW'(-num0) : NMW'(num0);
    mag1 = num1[DW+1] ? NMW'(-num1) : NMW'(num1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0]   <= sq_side_r[SQW];
      dv_n_r[0][0]   <= {mag0, {FB{1'b0}}};
      dv_n_r[0][1]   <= {mag1, {FB{1'b0}}};
      dv_sgn_r[0][0] <= num0[DW+1] ^ sq_side_r[SQW].a_neg;
      dv_sgn_r[0][1] <= num1[DW+1] ^ sq_side_r[SQW].a_neg;
      for (int j = 0; j < 2; j++) begin
        dv_rem_r[0][j] <= '0;
        dv_q_r[0][j]   <= '0;
      end
    end
  end

  // ---------------- two restoring dividers, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DVW:0] cur_nxt [2];
    logic         take_nxt [2];

    always_comb begin
      for (int j = 0; j < 2; j++) begin
        cur_nxt[j]  = {dv_rem_r[k-1][j], dv_n_r[k-1][j][QW-1]};
        take_nxt[j] = (cur_nxt[j] >= {1'b0, dv_side_r[k-1].den});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k] <= dv_side_r[k-1];
        for (int j = 0; j < 2; j++) begin
          dv_n_r[k][j]   <= dv_n_r[k-1][j] << 1;
          dv_rem_r[k][j] <= take_nxt[j] ? DVW'(cur_nxt[j] - {1'b0, dv_side_r[k-1].den})
                                        : DVW'(cur_nxt[j]);
          dv_q_r[k][j]   <= {dv_q_r[k-1][j][QW-2:0], take_nxt[j]};
          dv_sgn_r[k][j] <= dv_sgn_r[k-1][j];
        end
      end
    end
  end

  // ---------------- apply sign and saturate to the data range
  logic                 vs_r;
  side_t                side_s_r;
  logic signed [DW-1:0] t_s_r [2];
  logic signed [QW:0]   qs_nxt [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qs_nxt[j] = dv_sgn_r[QW][j] ? -$signed({1'b0, dv_q_r[QW][j]})
                                  :  $signed({1'b0, dv_q_r[QW][j]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_s_r <= dv_side_r[QW];
      for (int j = 0; j < 2; j++) begin
        if (qs_nxt[j] > MAXV) begin
          t_s_r[j] <= DW'(MAXV);
        end else if (qs_nxt[j] < MINV) begin
          t_s_r[j] <= DW'(MINV);
        end else begin
          t_s_r[j] <= DW'(qs_nxt[j]);
        end
      end
    end
  end

  // ---------------- order, interval test, status, into the output register
  logic signed [DW-1:0] r_lo, r_hi;
  logic                 in_lo, in_hi;
  qrii_pkg::out_item_t  res_nxt;

  always_comb begin
    if (t_s_r[0] > t_s_r[1]) begin
      r_lo = t_s_r[1];
      r_hi = t_s_r[0];
    end else begin
      r_lo = t_s_r[0];
      r_hi = t_s_r[1];
    end
    in_lo = (r_lo > side_s_r.lo) && (r_lo < side_s_r.hi);
    in_hi = (r_hi > side_s_r.lo) && (r_hi < side_s_r.hi);

    res_nxt.root   = '0;
    res_nxt.status = qrii_pkg::ST_NO_ROOT;
    if (side_s_r.a_zero) begin
      res_nxt.status = qrii_pkg::ST_A_ZERO;
    end else if (side_s_r.neg) begin
      res_nxt.status = qrii_pkg::ST_NEG_DISC;
    end else if (in_lo) begin
      res_nxt.status = qrii_pkg::ST_FOUND;
      res_nxt.root   = 32'(r_lo);
    end else if (in_hi) begin
      res_nxt.status = qrii_pkg::ST_FOUND;
      res_nxt.root   = 32'(r_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/qrii_checker.sv =====
`default_nettype none
`include "quadratic_root_in_interval_unit_assert.svh"
module qrii_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input qrii_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input qrii_pkg::out_item_t out_data
);

  `QRII_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)
  // failing statuses carry a zero root
  `QRII_ASSERT(a_zero_root, out_valid && out_data.status != qrii_pkg::ST_FOUND |-> out_data.root == '0)
  // the pipe only stalls behind a waiting result
  `QRII_ASSERT(a_ready_free, !out_valid |-> in_ready)
  // a result being taken never blocks input in that same cycle
  `QRII_ASSERT(a_ready_after, (out_valid && out_ready) |-> in_ready)

endmodule

bind quadratic_root_in_interval_unit qrii_checker u_qrii_checker (.*);
`default_nettype wire

// ===== tb/quadratic_root_in_interval_unit_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_in_interval_unit_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  qrii_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  qrii_pkg::out_item_t  out_data,
  output int                   fail_count,
  output int                   pending_count
);

  qrii_pkg::out_item_t pending_roots[$];

  // largest r in [0, 2^35) with r*r <= d
  function automatic logic [63:0] disc_isqrt(input logic [127:0] d);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp_root(input longint num, input longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic qrii_pkg::out_item_t pick_root(input qrii_pkg::in_item_t it);
    qrii_pkg::out_item_t res;
    longint a, b, c, lo, hi, s, r0, r1, t;
    logic signed [127:0] disc;
    a = it.coef_a; b = it.coef_b; c = it.coef_c;
    lo = it.bound_low; hi = it.bound_high;
    res.status = qrii_pkg::ST_NO_ROOT;
    res.root = '0;
    if (a == 0) begin
      res.status = qrii_pkg::ST_A_ZERO;
    end else begin
      disc = 128'(signed'(b)) * 128'(signed'(b))
           - 128'(signed'(4)) * 128'(signed'(a)) * 128'(signed'(c));
      if (disc < 0) begin
        res.status = qrii_pkg::ST_NEG_DISC;
      end else begin
        s = disc_isqrt(disc);
        r0 = clamp_root(-b + s, 2 * a);
        r1 = clamp_root(-b - s, 2 * a);
        if (r0 > r1) begin
          t = r0; r0 = r1; r1 = t;
        end
        if (r0 > lo && r0 < hi) begin
          res.status = qrii_pkg::ST_FOUND; res.root = r0[31:0];
        end else if (r1 > lo && r1 < hi) begin
          res.status = qrii_pkg::ST_FOUND; res.root = r1[31:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    qrii_pkg::out_item_t want;
    if (!rst_n) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready) pending_roots.push_back(pick_root(in_data));
      if (out_valid && out_ready) begin
        if (pending_roots.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t unexpected result status=%0d root=%h", $time,
                   out_data.status, out_data.root);
        end else begin
          want = pending_roots.pop_front();
          if (want.status !== out_data.status || want.root !== out_data.root) begin
            fail_count <= fail_count + 1;
            $display("%0t mismatch expected status=%0d root=%h actual status=%0d root=%h",
                     $time, want.status, want.root, out_data.status, out_data.root);
          end
        end
      end
      pending_count <= pending_roots.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/quadratic_root_in_interval_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_in_interval_unit_tb;

  localparam int LATENCY = 88;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  qrii_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  qrii_pkg::out_item_t out_data;
  int fail_count;
  int pending_count;
  longint cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  quadratic_root_in_interval_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  quadratic_root_in_interval_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on total cycles
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL quadratic_root_in_interval_unit");
        $finish;
      end
    end
  end

  // receiver stalls at the current rate, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one transfer: optional idle gap, then hold valid until accepted
  task automatic send_equation(input qrii_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(512)) - 256) <<< 16;
      2: return 32'($signed($urandom_range(8192)) - 4096) <<< 12;
      3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      4: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // mostly real roots: build from chosen roots r1, r2 so a(x-r1)(x-r2)
  function automatic qrii_pkg::in_item_t make_equation();
    qrii_pkg::in_item_t it;
    longint r1, r2, a;
    it.coef_a = rand_word();
    it.coef_b = rand_word();
    it.coef_c = rand_word();
    if ($urandom_range(99) < 60) begin
      a = $signed($urandom_range(64)) - 32;
      if (a == 0) a = 1;
      r1 = $signed($urandom_range(200)) - 100;
      r2 = $signed($urandom_range(200)) - 100;
      it.coef_a = 32'(a <<< 16);
      it.coef_b = 32'((-a * (r1 + r2)) <<< 16);
      it.coef_c = 32'((a * r1 * r2) <<< 16);
      it.coef_c = it.coef_c + 32'($signed($urandom_range(64)) - 32);
    end
    if ($urandom_range(9) == 0) it.coef_a = '0;
    if ($urandom_range(99) < 70) begin
      it.bound_low = 32'(($signed($urandom_range(240)) - 120) <<< 16);
      it.bound_high = it.bound_low + 32'($urandom_range(200) <<< 16);
    end else begin
      it.bound_low = rand_word();
      it.bound_high = rand_word();
    end
    return it;
  endfunction

  function automatic qrii_pkg::in_item_t eq(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] lo,
                                            input logic [31:0] hi);
    qrii_pkg::in_item_t it;
    it.coef_a = a; it.coef_b = b; it.coef_c = c;
    it.bound_low = lo; it.bound_high = hi;
    return it;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    int idle_phase;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: x^2-3x+2 roots 1 and 2, various windows
    send_equation(eq(ONE, -3 * ONE, 2 * ONE, 0, 3 * ONE));
    send_equation(eq(ONE, -3 * ONE, 2 * ONE, ONE, 3 * ONE));
    send_equation(eq(ONE, -3 * ONE, 2 * ONE, ONE, 2 * ONE));
    send_equation(eq(ONE, -3 * ONE, 2 * ONE, 3 * ONE, ONE));
    // a zero, negative discriminant, double root
    send_equation(eq(0, ONE, ONE, MINV, MAXV));
    send_equation(eq(0, 0, 0, 0, 0));
    send_equation(eq(ONE, 0, ONE, MINV, MAXV));
    send_equation(eq(ONE, -2 * ONE, ONE, 0, 2 * ONE));
    send_equation(eq(-ONE, 2 * ONE, -ONE, 0, 2 * ONE));
    // negative a, extremes and saturation
    send_equation(eq(-ONE, 0, 4 * ONE, MINV, MAXV));
    send_equation(eq(MAXV, MAXV, MAXV, MINV, MAXV));
    send_equation(eq(MINV, MINV, MINV, MINV, MAXV));
    send_equation(eq(MINV, MAXV, MAXV, MINV, MAXV));
    send_equation(eq(32'd1, MAXV, MINV, MINV, MAXV));
    send_equation(eq(32'd1, MINV, 0, MINV, MAXV));
    send_equation(eq(MAXV, 0, MINV, MINV, MAXV));
    send_equation(eq(32'hffffffff, 32'hffffffff, 32'hffffffff, MINV, MAXV));
    send_equation(eq(ONE, 0, 0, MINV, MAXV));
    send_equation(eq(ONE, 0, -ONE, MAXV, MINV));
    send_equation(eq(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                     32'h5555_5555));

    // random, across idling phases
    for (int n = 0; n < 1550; n++) begin
      idle_phase = (n / 130) % 4;
      case (idle_phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      send_equation(make_equation());
    end
    in_valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS quadratic_root_in_interval_unit");
    end else begin
      $display("FAIL quadratic_root_in_interval_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== quadratic_root_in_interval_unit.f =====
+incdir+src
src/qrii_pkg.sv
src/quadratic_root_in_interval_unit.sv
src/qrii_checker.sv
tb/quadratic_root_in_interval_unit_checker.sv
tb/quadratic_root_in_interval_unit_tb.sv
